FILE: src/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// shared types and constants of the mmio mov instruction decoder
// ----------------------------------------------------------------------------
package mmd_pkg;

  // longest instruction accepted before the too-long fault
  localparam int MAX_INSTR_BYTES = 16;
  localparam int LEN_W           = 5;
  localparam logic [LEN_W-1:0] LEN_SATURATE = LEN_W'(MAX_INSTR_BYTES + 1);

  // opcodes handled
  localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
  localparam logic [7:0] OP_MOV_STORE = 8'h89;
  localparam logic [7:0] OP_MOV_IMM   = 8'hC7;

  // skipped prefixes
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_REPNE  = 8'hF2;
  localparam logic [7:0] PFX_REP    = 8'hF3;
  localparam logic [7:0] PFX_CS     = 8'h2E;
  localparam logic [7:0] PFX_DS     = 8'h3E;
  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [3:0] REX_NIBBLE = 4'h4;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_STORE_REG = 2'd1,
    ACT_STORE_IMM = 2'd2,
    ACT_FAULT     = 2'd3
  } mmd_action_t;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_TOO_LONG   = 3'd1,
    FLT_TRUNCATED  = 3'd2,
    FLT_NO_MODRM   = 3'd3,
    FLT_REG_DIRECT = 3'd4,
    FLT_C7_REG     = 3'd5,
    FLT_NO_IMM     = 3'd6,
    FLT_BAD_OPCODE = 3'd7
  } mmd_fault_t;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_PREFIX       = 4'b0001,
    PH_AFTER_REX    = 4'b0010,
    PH_AFTER_OPCODE = 4'b0100,
    PH_AFTER_MODRM  = 4'b1000
  } mmd_phase_t;

  // one input word
  typedef struct packed {
    logic [7:0]  instr_byte;
    logic        last_byte;
    logic [63:0] access_address;
  } mmd_word_t;

  // one decoded result
  typedef struct packed {
    mmd_action_t      action;
    mmd_fault_t       fault_code;
    logic [3:0]       reg_index;
    logic [31:0]      immediate;
    logic [63:0]      device_address;
    logic [LEN_W-1:0] instr_length;
  } mmd_result_t;

endpackage

FILE: src/mmd_in_stage.sv
// ----------------------------------------------------------------------------
// mmd_in_stage
// input register holding one word until the parser consumes it
// ----------------------------------------------------------------------------
module mmd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_instr_byte,
  input  logic              in_last_byte,
  input  logic [63:0]       in_access_address,
  input  logic              take,
  output logic              word_valid,
  output mmd_pkg::mmd_word_t word
);

  logic               valid_r;
  mmd_pkg::mmd_word_t word_r;

  // full and not drained this cycle
  assign in_stall   = valid_r && !take;
  assign word_valid = valid_r;
  assign word       = word_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r.instr_byte     <= in_instr_byte;
      word_r.last_byte      <= in_last_byte;
      word_r.access_address <= in_access_address;
    end
  end

endmodule

FILE: src/mmd_parser.sv
// ----------------------------------------------------------------------------
// mmd_parser
// prefix, rex, opcode and modrm tracking with the final decode on the last byte
// ----------------------------------------------------------------------------
module mmd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  mmd_pkg::mmd_word_t   word,
  output mmd_pkg::mmd_result_t result
);

  mmd_pkg::mmd_phase_t      phase_r, phase_nxt;
  logic                     rex_r, rex_nxt;
  logic [7:0]               opcode_r, opcode_nxt;
  logic [7:0]               modrm_r, modrm_nxt;
  logic [mmd_pkg::LEN_W-1:0] count_r, count_nxt;
  logic [2:0]               after_r, after_nxt;
  logic [31:0]              tail_r, tail_nxt;
  logic [7:0]               b;
  logic                     is_prefix;

  assign b = word.instr_byte;

  // skipped prefix match
  always_comb begin
    is_prefix = (b == mmd_pkg::PFX_OPSIZE) || (b == mmd_pkg::PFX_REPNE) ||
                (b == mmd_pkg::PFX_REP)    || (b == mmd_pkg::PFX_CS)    ||
                (b == mmd_pkg::PFX_DS)     || (b == mmd_pkg::PFX_ES)    ||
                (b == mmd_pkg::PFX_FS)     || (b == mmd_pkg::PFX_GS)    ||
                (b == mmd_pkg::PFX_SS);
  end

  // state update for this byte
  always_comb begin
    phase_nxt  = phase_r;
    rex_nxt    = rex_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    after_nxt  = after_r;
    count_nxt  = (count_r < mmd_pkg::LEN_SATURATE) ? count_r + 1'b1 : count_r;
    tail_nxt   = {b, tail_r[31:8]};
    unique case (phase_r)
      mmd_pkg::PH_PREFIX: begin
        if (is_prefix) begin
          phase_nxt = mmd_pkg::PH_PREFIX;
        end else if (b[7:4] == mmd_pkg::REX_NIBBLE) begin
          rex_nxt   = b[2];
          phase_nxt = mmd_pkg::PH_AFTER_REX;
        end else begin
          opcode_nxt = b;
          phase_nxt  = mmd_pkg::PH_AFTER_OPCODE;
        end
      end
      mmd_pkg::PH_AFTER_REX: begin
        opcode_nxt = b;
        phase_nxt  = mmd_pkg::PH_AFTER_OPCODE;
      end
      mmd_pkg::PH_AFTER_OPCODE: begin
        modrm_nxt = b;
        after_nxt = 3'd0;
        phase_nxt = mmd_pkg::PH_AFTER_MODRM;
      end
      mmd_pkg::PH_AFTER_MODRM: begin
        // only "at least four" matters, so saturate at four
        if (after_r < 3'd4) after_nxt = after_r + 3'd1;
      end
      default: begin
        phase_nxt = mmd_pkg::PH_PREFIX;
      end
    endcase
  end

  // final decode, in fault priority order
  always_comb begin
    result                = '0;
    result.action         = mmd_pkg::ACT_FAULT;
    result.fault_code     = mmd_pkg::FLT_NONE;
    result.instr_length   = count_nxt;
    if (count_nxt > mmd_pkg::LEN_W'(mmd_pkg::MAX_INSTR_BYTES)) begin
      result.fault_code = mmd_pkg::FLT_TOO_LONG;
    end else if (phase_nxt == mmd_pkg::PH_PREFIX || phase_nxt == mmd_pkg::PH_AFTER_REX) begin
      result.fault_code = mmd_pkg::FLT_TRUNCATED;
    end else if (phase_nxt == mmd_pkg::PH_AFTER_OPCODE) begin
      result.fault_code = mmd_pkg::FLT_NO_MODRM;
    end else if (modrm_nxt[7:6] == 2'b11) begin
      result.fault_code = mmd_pkg::FLT_REG_DIRECT;
    end else if (opcode_nxt == mmd_pkg::OP_MOV_LOAD || opcode_nxt == mmd_pkg::OP_MOV_STORE) begin
      result.action         = (opcode_nxt == mmd_pkg::OP_MOV_LOAD) ?
                              mmd_pkg::ACT_LOAD : mmd_pkg::ACT_STORE_REG;
      result.reg_index      = {rex_nxt, modrm_nxt[5:3]};
      result.device_address = word.access_address;
    end else if (opcode_nxt == mmd_pkg::OP_MOV_IMM) begin
      if (modrm_nxt[5:3] != 3'd0) begin
        result.fault_code = mmd_pkg::FLT_C7_REG;
      end else if (after_nxt < 3'd4) begin
        result.fault_code = mmd_pkg::FLT_NO_IMM;
      end else begin
        result.action         = mmd_pkg::ACT_STORE_IMM;
        result.immediate      = tail_nxt;
        result.device_address = word.access_address;
      end
    end else begin
      result.fault_code = mmd_pkg::FLT_BAD_OPCODE;
    end
  end

  // parse state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (take && word.last_byte)) begin
      phase_r  <= mmd_pkg::PH_PREFIX;
      rex_r    <= 1'b0;
      opcode_r <= 8'd0;
      modrm_r  <= 8'd0;
      count_r  <= '0;
      after_r  <= 3'd0;
      tail_r   <= 32'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      rex_r    <= rex_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      count_r  <= count_nxt;
      after_r  <= after_nxt;
      tail_r   <= tail_nxt;
    end
  end

endmodule

FILE: src/mmd_out_stage.sv
// ----------------------------------------------------------------------------
// mmd_out_stage
// result register towards the consumer
// ----------------------------------------------------------------------------
module mmd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mmd_pkg::mmd_result_t result,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_free,
  output mmd_pkg::mmd_result_t held
);

  logic                 valid_r;
  mmd_pkg::mmd_result_t held_r;

  assign out_valid = valid_r;
  assign out_free  = !valid_r || !out_stall;
  assign held      = held_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= result;
    end
  end

endmodule

FILE: src/mmio_mov_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// mmio_mov_instruction_decoder_top
// decodes a faulting mov instruction, one byte per word, into a device action
// ----------------------------------------------------------------------------
// One instruction byte is taken per word and a new word can be accepted every
// cycle unless a last byte waits on a busy result slot. Bytes pass through an
// input register, are parsed against the prefix, rex, opcode and modrm phase
// register, and a word marked as the last byte moves from the input register
// into the output register as one result once that register is free, ready to
// leave while out_stall is low; other words produce nothing. The rate is set
// by the single phase register update per byte. A stalled result holds the
// input side only once a further last byte is waiting behind it.
module mmio_mov_instruction_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_instr_byte,
  input  logic        in_last_byte,
  input  logic [63:0] in_access_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [2:0]  out_fault_code,
  output logic [3:0]  out_reg_index,
  output logic [31:0] out_immediate,
  output logic [63:0] out_device_address,
  output logic [4:0]  out_instr_length
);

  logic                 word_valid;
  mmd_pkg::mmd_word_t   word;
  logic                 take;
  logic                 out_free;
  mmd_pkg::mmd_result_t result;
  mmd_pkg::mmd_result_t held;

  // a word moves on unless it is a last byte and the result slot is busy
  assign take = word_valid && (!word.last_byte || out_free);

  mmd_in_stage u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_instr_byte     (in_instr_byte),
    .in_last_byte      (in_last_byte),
    .in_access_address (in_access_address),
    .take              (take),
    .word_valid        (word_valid),
    .word              (word)
  );

  mmd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .word   (word),
    .result (result)
  );

  mmd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && word.last_byte),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_free  (out_free),
    .held      (held)
  );

  // result fields
  assign out_action         = held.action;
  assign out_fault_code     = held.fault_code;
  assign out_reg_index      = held.reg_index;
  assign out_immediate      = held.immediate;
  assign out_device_address = held.device_address;
  assign out_instr_length   = held.instr_length;

  // a fault carries a code and a non-fault carries none
  a_fault_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_action == mmd_pkg::ACT_FAULT) ==
                   (out_fault_code != mmd_pkg::FLT_NONE)))
    else $error("fault code does not match action");

  // faults clear register, immediate and address
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == mmd_pkg::ACT_FAULT) |->
      (out_reg_index == 4'd0 && out_immediate == 32'd0 && out_device_address == 64'd0))
    else $error("fault result carries payload");

  // over-length always wins
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_instr_length > 5'(mmd_pkg::MAX_INSTR_BYTES)) |->
      (out_fault_code == mmd_pkg::FLT_TOO_LONG))
    else $error("over-length instruction not faulted");

  // a successful store immediate needs opcode, modrm and four bytes
  a_imm_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == mmd_pkg::ACT_STORE_IMM) |->
      (out_instr_length >= 5'd6 && out_reg_index == 4'd0))
    else $error("store immediate with short instruction");

  // a result is only loaded into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_instr_length) && $stable(out_action)))
    else $error("held result overwritten");

endmodule
